// ----- rtl/fsc_pkg.sv -----
// Shared constants, codes and interface structs for the fermion state counter.
package fsc_pkg;

    localparam int MAX_SITES_DEF = 64;
    localparam int DIM_W         = 63;
    localparam int NUM_W         = 8;
    localparam int DEN_W         = 7;
    localparam int PROD_W        = DIM_W + NUM_W;
    localparam int DIV_DIGITS    = (PROD_W + 7) / 8;
    localparam int WORK_W        = DIV_DIGITS * 8;

    localparam logic [DIM_W-1:0] DIM_MAX = {DIM_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_FREE    = 2'd0,
        MODE_FREE_SZ = 2'd1,
        MODE_PROJ    = 2'd2,
        MODE_PROJ_SZ = 2'd3
    } t_mode;

    typedef struct packed {
        logic             start;
        logic [DIM_W-1:0] opa;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_md_req;

    typedef struct packed {
        logic             done;
        logic             sat;
        logic [DIM_W-1:0] quo;
    } t_md_rsp;

endpackage

// ----- rtl/fsc_muldiv.sv -----
// Shared multiply-then-divide unit: quotient of opa times num over a small divisor.
module fsc_muldiv (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fsc_pkg::t_md_req i_req,
    output fsc_pkg::t_md_rsp o_rsp
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } t_md_state;

    localparam int CNT_W = $clog2(fsc_pkg::DIV_DIGITS);

    t_md_state                    r_state, n_state;
    logic [fsc_pkg::WORK_W-1:0]   r_work, n_work;
    logic [fsc_pkg::DEN_W-1:0]    r_den;
    logic [fsc_pkg::DEN_W-1:0]    r_rem, n_rem;
    logic [CNT_W-1:0]             r_cnt;
    logic [fsc_pkg::PROD_W-1:0]   w_prod;
    logic [7:0]                   w_qbyte;

    assign w_prod = fsc_pkg::PROD_W'(i_req.opa) * fsc_pkg::PROD_W'(i_req.num);

    always_comb begin
        logic [fsc_pkg::DEN_W:0] t;
        logic [7:0]              digit;
        logic [fsc_pkg::DEN_W-1:0] rem;
        digit   = r_work[fsc_pkg::WORK_W-1 -: 8];
        rem     = r_rem;
        w_qbyte = '0;
        for (int j = 7; j >= 0; j--) begin
            t = {rem, digit[j]};
            if (t >= {1'b0, r_den}) begin
                rem        = fsc_pkg::DEN_W'(t - {1'b0, r_den});
                w_qbyte[j] = 1'b1;
            end else begin
                rem = t[fsc_pkg::DEN_W-1:0];
            end
        end
        n_rem  = rem;
        n_work = {r_work[fsc_pkg::WORK_W-9:0], w_qbyte};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.start) begin
                    n_state = (i_req.den == fsc_pkg::DEN_W'(1)) ? ST_DONE : ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == CNT_W'(fsc_pkg::DIV_DIGITS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_req.start) begin
            r_work <= fsc_pkg::WORK_W'(w_prod);
            r_den  <= i_req.den;
            r_rem  <= '0;
            r_cnt  <= '0;
        end else if (r_state == ST_DIV) begin
            r_work <= n_work;
            r_rem  <= n_rem;
            r_cnt  <= r_cnt + CNT_W'(1);
        end
    end

    assign o_rsp.done = (r_state == ST_DONE);
    assign o_rsp.sat  = |r_work[fsc_pkg::WORK_W-1:fsc_pkg::DIM_W];
    assign o_rsp.quo  = r_work[fsc_pkg::DIM_W-1:0];

endmodule

// ----- rtl/fermion_state_count_core.sv -----
// Top level: counts spin-1/2 fermion basis states as a product of binomials.
// Each multiply-divide step runs on the shared unit, which skips the division when the divisor is one.
// A second factor, if any, follows the first; a doubling factor multiplies by two at each step.
// Binomial orders are reduced to min(k, n - k); an empty factor or saturation ends the run early.
// The result turns valid as the block turns ready; the next item is taken while it waits.
// Synchronous active-low reset clears the sequencer and the output valid flag.
module fermion_state_count_core #(
    parameter int MAX_SITES = fsc_pkg::MAX_SITES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // particles[7:0], sites[14:8], spin_up[22:15], zero pad
    input  logic [1:0]  i_s_tuser,  // mode[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,  // dimension[62:0], zero pad
    output logic [0:0]  o_m_tuser   // overflow[0]
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    localparam logic [6:0] MaxSites = 7'(MAX_SITES);

    t_state                      r_state, n_state;
    logic [fsc_pkg::DIM_W-1:0]   r_acc;
    logic                        r_sat;
    logic [7:0]                  r_n, r_i, r_k;
    logic                        r_dbl;
    logic                        r_has2;
    logic [7:0]                  r_n2, r_k2;
    logic                        r_dbl2;
    logic                        r_out_valid;
    logic [fsc_pkg::DIM_W-1:0]   r_out_dim;
    logic                        r_out_ovf;

    fsc_pkg::t_md_req            w_req;
    fsc_pkg::t_md_rsp            w_rsp;

    logic                        w_accept;
    logic                        w_out_load;
    logic [6:0]                  w_sites;
    logic signed [9:0]           w_n1, w_k1, w_n2, w_k2;
    logic signed [9:0]           w_kr1, w_kr2;
    logic                        w_use2, w_dbl2, w_zero;
    fsc_pkg::t_mode              w_mode;

    assign w_mode     = fsc_pkg::t_mode'(i_s_tuser);
    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_load = (r_state == ST_FIN) && (!r_out_valid || i_m_tready);

    always_comb begin
        logic signed [9:0] sv, nv, uv;
        w_sites = (i_s_tdata[14:8] > MaxSites) ? MaxSites : i_s_tdata[14:8];
        sv = {3'b000, w_sites};
        nv = {2'b00, i_s_tdata[7:0]};
        uv = {2'b00, i_s_tdata[22:15]};
        w_n2   = '0;
        w_k2   = '0;
        w_use2 = 1'b0;
        w_dbl2 = 1'b0;
        unique case (w_mode)
            fsc_pkg::MODE_FREE: begin
                w_n1 = sv + sv;
                w_k1 = nv;
            end
            fsc_pkg::MODE_FREE_SZ: begin
                w_n1   = sv;
                w_k1   = uv;
                w_n2   = sv;
                w_k2   = nv - uv;
                w_use2 = 1'b1;
            end
            fsc_pkg::MODE_PROJ: begin
                w_n1   = sv;
                w_k1   = sv - nv;
                w_k2   = nv;
                w_dbl2 = 1'b1;
            end
            fsc_pkg::MODE_PROJ_SZ: begin
                w_n1   = sv;
                w_k1   = sv - nv;
                w_n2   = nv;
                w_k2   = uv;
                w_use2 = 1'b1;
            end
            default: begin
                w_n1 = sv;
                w_k1 = sv;
            end
        endcase
        w_zero = (w_k1 < 0) || (w_k1 > w_n1)
              || (w_use2 && ((w_k2 < 0) || (w_k2 > w_n2)));
        w_kr1  = (w_k1 > w_n1 - w_k1) ? w_n1 - w_k1 : w_k1;
        w_kr2  = (w_k2 > w_n2 - w_k2) ? w_n2 - w_k2 : w_k2;
    end

    assign w_req.start = (r_state == ST_RUN) && (r_i != r_k);
    assign w_req.opa   = r_acc;
    assign w_req.num   = r_dbl ? 8'd2 : r_n - r_i;
    assign w_req.den   = r_dbl ? 7'd1 : r_i[6:0] + 7'd1;

    fsc_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_zero ? ST_FIN : ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_i != r_k) begin
                    n_state = ST_WAIT;
                end else if (!r_has2) begin
                    n_state = ST_FIN;
                end
            end
            ST_WAIT: begin
                if (w_rsp.done) begin
                    n_state = w_rsp.sat ? ST_FIN : ST_RUN;
                end
            end
            ST_FIN: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_acc  <= w_zero ? '0 : fsc_pkg::DIM_W'(1);
            r_sat  <= 1'b0;
            r_n    <= w_n1[7:0];
            r_k    <= w_kr1[7:0];
            r_i    <= '0;
            r_dbl  <= 1'b0;
            r_has2 <= w_use2 || w_dbl2;
            r_n2   <= w_n2[7:0];
            r_k2   <= w_dbl2 ? w_k2[7:0] : w_kr2[7:0];
            r_dbl2 <= w_dbl2;
        end else if (r_state == ST_RUN && r_i == r_k && r_has2) begin
            r_n    <= r_n2;
            r_k    <= r_k2;
            r_i    <= '0;
            r_dbl  <= r_dbl2;
            r_has2 <= 1'b0;
        end else if (r_state == ST_WAIT && w_rsp.done) begin
            if (w_rsp.sat) begin
                r_sat <= 1'b1;
                r_acc <= fsc_pkg::DIM_MAX;
            end else begin
                r_acc <= w_rsp.quo;
                r_i   <= r_i + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_dim <= r_acc;
            r_out_ovf <= r_sat;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = {1'b0, r_out_dim};
    assign o_m_tuser[0] = r_out_ovf;

endmodule
